FILE: sv/smfc_pkg.sv
// Shared types, codes and byte tables for the MAIL FROM line checker.
// No dependencies; used by smfc_classify, smfc_parse and smtp_mail_from_checker_unit.
package smfc_pkg;

  // Parse phase, one-hot
  typedef enum logic [4:0] {
    PH_CMD       = 5'b00001,
    PH_BLANKS    = 5'b00010,
    PH_LOCAL     = 5'b00100,
    PH_DOM_START = 5'b01000,
    PH_DOM_IN    = 5'b10000
  } phase_t;

  // Verdict codes
  localparam logic [2:0] VERD_OK      = 3'd0;
  localparam logic [2:0] VERD_CMD     = 3'd1;
  localparam logic [2:0] VERD_PATH    = 3'd2;
  localparam logic [2:0] VERD_MAILBOX = 3'd3;
  localparam logic [2:0] VERD_ELEMENT = 3'd4;

  // Position of the colon, the last byte of the command word
  localparam logic [3:0] CMD_LAST = 4'd9;

  // Byte constants
  localparam logic [7:0] CH_LT    = 8'h3C; // '<'
  localparam logic [7:0] CH_GT    = 8'h3E; // '>'
  localparam logic [7:0] CH_AT    = 8'h40; // '@'
  localparam logic [7:0] CH_DOT   = 8'h2E; // '.'
  localparam logic [7:0] CH_COLON = 8'h3A; // ':'
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BSL   = 8'h5C; // backslash

  typedef struct packed {
    logic blank;
    logic special;
    logic letter;
    logic digit;
    logic lt;
    logic gt;
    logic at;
    logic dot;
  } byte_class_t;

  // Expected byte at each position of "MAIL FROM:"
  function automatic logic [7:0] cmd_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h4D; // M
      4'd1:    c = 8'h41; // A
      4'd2:    c = 8'h49; // I
      4'd3:    c = 8'h4C; // L
      4'd4:    c = CH_SPACE;
      4'd5:    c = 8'h46; // F
      4'd6:    c = 8'h52; // R
      4'd7:    c = 8'h4F; // O
      4'd8:    c = 8'h4D; // M
      4'd9:    c = CH_COLON;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_special(input logic [7:0] b);
    return (b == CH_LT) || (b == CH_GT) || (b == 8'h28) || (b == 8'h29) ||
           (b == 8'h5B) || (b == 8'h5D) || (b == CH_BSL) || (b == CH_DOT) ||
           (b == 8'h2C) || (b == 8'h3B) || (b == CH_COLON) || (b == CH_AT) ||
           (b == 8'h22);
  endfunction

endpackage

FILE: sv/smfc_classify.sv
// Byte classifier for the MAIL FROM line checker.
// Depends on smfc_pkg.
module smfc_classify (
  input  logic [7:0]          byte_in,
  output smfc_pkg::byte_class_t cls
);
  import smfc_pkg::*;

  always_comb begin
    cls.blank   = (byte_in == CH_SPACE) || (byte_in == CH_TAB);
    cls.special = is_special(byte_in);
    cls.letter  = ((byte_in >= 8'h41) && (byte_in <= 8'h5A)) ||
                  ((byte_in >= 8'h61) && (byte_in <= 8'h7A));
    cls.digit   = (byte_in >= 8'h30) && (byte_in <= 8'h39);
    cls.lt      = (byte_in == CH_LT);
    cls.gt      = (byte_in == CH_GT);
    cls.at      = (byte_in == CH_AT);
    cls.dot     = (byte_in == CH_DOT);
  end

endmodule

FILE: sv/smfc_parse.sv
// Parse state and per-byte transition of the MAIL FROM line checker.
// Depends on smfc_pkg.
module smfc_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic [7:0]            byte_in,
  input  logic                  last,
  input  smfc_pkg::byte_class_t cls,
  output logic                  hit,
  output logic [2:0]            code
);
  import smfc_pkg::*;

  phase_t     phase, phase_next;
  logic [3:0] cmd_idx, cmd_idx_next;
  logic       given, given_next;
  logic       local_seen, local_seen_next;
  logic       local_byte;

  assign local_byte = !cls.special && !cls.blank;

  always_comb begin
    phase_next      = phase;
    cmd_idx_next    = cmd_idx;
    given_next      = given;
    local_seen_next = local_seen;
    hit             = 1'b0;
    code            = VERD_OK;

    if (!given) begin
      unique case (phase)
        PH_CMD: begin
          if (byte_in == cmd_char(cmd_idx)) begin
            if (cmd_idx == CMD_LAST) begin
              phase_next   = PH_BLANKS;
              cmd_idx_next = '0;
            end else begin
              cmd_idx_next = cmd_idx + 4'd1;
            end
          end else begin
            hit  = 1'b1;
            code = VERD_CMD;
          end
        end
        PH_BLANKS: begin
          if (cls.lt) begin
            phase_next      = PH_LOCAL;
            local_seen_next = 1'b0;
          end else if (!cls.blank) begin
            hit  = 1'b1;
            code = VERD_PATH;
          end
        end
        PH_LOCAL: begin
          if (!local_seen) begin
            if (cls.gt) begin
              hit  = 1'b1;
              code = VERD_OK;
            end else if (local_byte) begin
              local_seen_next = 1'b1;
            end else begin
              hit  = 1'b1;
              code = VERD_PATH;
            end
          end else if (!local_byte) begin
            if (cls.at) begin
              phase_next = PH_DOM_START;
            end else begin
              hit  = 1'b1;
              code = VERD_MAILBOX;
            end
          end
        end
        PH_DOM_START: begin
          if (cls.letter) begin
            phase_next = PH_DOM_IN;
          end else begin
            hit  = 1'b1;
            code = VERD_ELEMENT;
          end
        end
        PH_DOM_IN: begin
          if (cls.dot) begin
            phase_next = PH_DOM_START;
          end else if (cls.gt) begin
            hit  = 1'b1;
            code = VERD_OK;
          end else if (!cls.letter && !cls.digit) begin
            hit  = 1'b1;
            code = VERD_PATH;
          end
        end
        default: begin
          hit  = 1'b1;
          code = VERD_CMD;
        end
      endcase

      // line ended while still open: judge by where it stopped
      if (!hit && last) begin
        hit = 1'b1;
        unique case (phase_next)
          PH_CMD:       code = VERD_CMD;
          PH_BLANKS:    code = VERD_PATH;
          PH_LOCAL:     code = local_seen_next ? VERD_MAILBOX : VERD_PATH;
          PH_DOM_START: code = VERD_ELEMENT;
          PH_DOM_IN:    code = VERD_PATH;
          default:      code = VERD_CMD;
        endcase
      end

      if (hit) begin
        given_next = 1'b1;
      end
    end

    // rearm after the last byte of every line
    if (last) begin
      phase_next      = PH_CMD;
      cmd_idx_next    = '0;
      given_next      = 1'b0;
      local_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_CMD;
      cmd_idx    <= '0;
      given      <= 1'b0;
      local_seen <= 1'b0;
    end else if (adv) begin
      phase      <= phase_next;
      cmd_idx    <= cmd_idx_next;
      given      <= given_next;
      local_seen <= local_seen_next;
    end
  end

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    adv && last |=> phase == PH_CMD && cmd_idx == '0 && !given && !local_seen)
    else $error("parser not rearmed after last byte");

  a_seen_phase: assert property (@(posedge clk) disable iff (rst)
    local_seen |-> phase != PH_CMD && phase != PH_BLANKS)
    else $error("local part flag set before the path opened");

  a_no_second: assert property (@(posedge clk) disable iff (rst)
    adv && given |-> !hit)
    else $error("second verdict for one line");

endmodule

FILE: sv/smtp_mail_from_checker_unit.sv
// Top level of the MAIL FROM line checker: input register, parse step, result register.
// Depends on smfc_pkg, smfc_classify and smfc_parse.
//
// Checks one command line, one byte per transfer, against "MAIL FROM:", optional
// blanks, '<', a local part, '@', a dot-separated domain and '>'. Exactly one
// verdict transfer is produced per line: at the byte that decides it, or at the
// byte marked by line_end if nothing decided earlier. Bytes after a verdict are
// swallowed up to line_end, after which the checker rearms for the next line.
// Verdicts: 0 accepted, 1 command word error, 2 path error, 3 mailbox error,
// 4 element error. "<>" is accepted; anything after '>' is not inspected.
// Throughput is one byte per clock unless a held verdict meets an output stall,
// limited by the single parse step that sits between the input register and the
// result register. A deciding byte's verdict enters the result register when the
// byte advances, and is transferred once the output is not stalled. The input side
// keeps accepting while a verdict waits, and stalls only when both the input
// register and the result register are full and the output is stalled.
module smtp_mail_from_checker_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] byte_in,
  input  logic       line_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] verdict
);
  import smfc_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        adv;
  logic        hit;
  logic [2:0]  code;
  byte_class_t cls;

  // advance the held byte once the result register can take its outcome
  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !adv;

  // input register: load on every transfer, drop when the byte advances
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= byte_in;
      s1_last <= line_end;
    end
  end

  smfc_classify u_classify (
    .byte_in (s1_byte),
    .cls     (cls)
  );

  smfc_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .byte_in (s1_byte),
    .last    (s1_last),
    .cls     (cls),
    .hit     (hit),
    .code    (code)
  );

  // result register: hold while stalled, replace on advance
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= hit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && hit) begin
      verdict <= code;
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> verdict <= VERD_ELEMENT)
    else $error("verdict code out of range");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |=> out_valid == $past(out_valid && out_stall))
    else $error("result appeared without a byte");

endmodule

FILE: verif/tb_smtp_mail_from_checker_unit.sv
// Self-checking bench for smtp_mail_from_checker_unit: directed and random MAIL FROM lines.
// Byte transfers go in bursts, verdict transfers see random stalls, and an in-bench parser predicts.
// Depends on smfc_pkg and the checker RTL only.
module tb_smtp_mail_from_checker_unit;
  import smfc_pkg::*;

  localparam int          RANDOM_BYTES = 1550;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 10;
  localparam logic [79:0] CMD_WORD     = "MAIL FROM:";

  // One byte of a command line as it waits for its input transfer
  typedef struct packed {
    logic [7:0] data;
    logic       is_tail;
  } line_byte_t;

  // Output-side stall behaviour, picked anew at random whenever its mode count runs out
  typedef enum int {
    RX_FLOWING,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] byte_in   = 8'h00;
  logic       line_end  = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] verdict;

  line_byte_t line_q[$];      // bytes still to be transferred
  logic [2:0] verdict_q[$];   // verdicts predicted but not yet received
  line_byte_t next_byte;
  logic [2:0] want_verdict;

  // Bench copy of the parser state
  phase_t     chk_phase;
  int         cmd_pos;
  logic       verdict_done;
  logic       local_taken;

  int         bytes_taken = 0;
  int         total_bytes = 0;
  int         fail_count  = 0;
  int         cycles      = 0;
  int         burst_left  = 0;
  int         gap_left    = 0;
  rx_mode_t   rx_mode     = RX_FLOWING;
  int         mode_left   = 0;

  smtp_mail_from_checker_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .byte_in  (byte_in),
    .line_end (line_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .verdict  (verdict)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Byte classes
  // ---------------------------------------------------------------------------
  function automatic logic addr_special(input logic [7:0] b);
    case (b)
      CH_LT, CH_GT, CH_AT, CH_DOT, CH_COLON, CH_BSL,
      8'h28, 8'h29, 8'h5B, 8'h5D, 8'h2C, 8'h3B, 8'h22: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic mailbox_byte(input logic [7:0] b);
    return !addr_special(b) && b != CH_SPACE && b != CH_TAB;
  endfunction

  function automatic logic alpha_byte(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic numeral_byte(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  // ---------------------------------------------------------------------------
  // Verdict prediction: advance the bench parser by one accepted byte
  // ---------------------------------------------------------------------------
  function automatic void rearm_parser();
    chk_phase    = PH_CMD;
    cmd_pos      = 0;
    verdict_done = 1'b0;
    local_taken  = 1'b0;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic tail);
    logic       decided;
    logic [2:0] v;
    decided = 1'b0;
    v       = VERD_OK;
    if (verdict_done) begin
      // Swallow everything after a verdict; rearm on the line's last byte
      if (tail) rearm_parser();
    end else begin
      case (chk_phase)
        PH_CMD: begin
          if (b != CMD_WORD[79 - 8*cmd_pos -: 8]) begin
            decided = 1'b1;
            v       = VERD_CMD;
          end else if (cmd_pos == CMD_LAST) begin
            chk_phase = PH_BLANKS;
          end else begin
            cmd_pos = cmd_pos + 1;
          end
        end
        PH_BLANKS: begin
          if (b == CH_LT) begin
            chk_phase   = PH_LOCAL;
            local_taken = 1'b0;
          end else if (b != CH_SPACE && b != CH_TAB) begin
            decided = 1'b1;
            v       = VERD_PATH;
          end
        end
        PH_LOCAL: begin
          if (!local_taken) begin
            // Right after '<': "<>" is the empty path, anything odd is a path error
            if (b == CH_GT) begin
              decided = 1'b1;
              v       = VERD_OK;
            end else if (mailbox_byte(b)) begin
              local_taken = 1'b1;
            end else begin
              decided = 1'b1;
              v       = VERD_PATH;
            end
          end else if (!mailbox_byte(b)) begin
            if (b == CH_AT) begin
              chk_phase = PH_DOM_START;
            end else begin
              decided = 1'b1;
              v       = VERD_MAILBOX;
            end
          end
        end
        PH_DOM_START: begin
          // A label must open with a letter, also after a dot
          if (alpha_byte(b)) begin
            chk_phase = PH_DOM_IN;
          end else begin
            decided = 1'b1;
            v       = VERD_ELEMENT;
          end
        end
        PH_DOM_IN: begin
          if (b == CH_DOT) begin
            chk_phase = PH_DOM_START;
          end else if (b == CH_GT) begin
            decided = 1'b1;
            v       = VERD_OK;
          end else if (!alpha_byte(b) && !numeral_byte(b)) begin
            decided = 1'b1;
            v       = VERD_PATH;
          end
        end
        default: begin
          decided = 1'b1;
          v       = VERD_CMD;
        end
      endcase

      // Line ends while still open: the verdict follows from where it stopped
      if (!decided && tail) begin
        decided = 1'b1;
        case (chk_phase)
          PH_CMD:       v = VERD_CMD;
          PH_BLANKS:    v = VERD_PATH;
          PH_LOCAL:     v = local_taken ? VERD_MAILBOX : VERD_PATH;
          PH_DOM_START: v = VERD_ELEMENT;
          PH_DOM_IN:    v = VERD_PATH;
          default:      v = VERD_CMD;
        endcase
      end

      if (decided) begin
        verdict_q.push_back(v);
        if (tail) rearm_parser();
        else verdict_done = 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Line generation
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_mailbox_byte();
    logic [7:0] b;
    do b = any_byte(); while (!mailbox_byte(b));
    return b;
  endfunction

  function automatic logic [7:0] pick_special();
    logic [7:0] b;
    do b = any_byte(); while (!addr_special(b));
    return b;
  endfunction

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h41, 8'h5A));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic logic [7:0] pick_numeral();
    return 8'($urandom_range(8'h30, 8'h39));
  endfunction

  function automatic logic [7:0] pick_blank();
    return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB;
  endfunction

  task automatic queue_line(input logic [7:0] ln[$]);
    line_byte_t item;
    for (int k = 0; k < ln.size(); k++) begin
      item.data    = ln[k];
      item.is_tail = (k == ln.size() - 1);
      line_q.push_back(item);
    end
  endtask

  task automatic queue_text(input string s);
    logic [7:0] ln[$];
    for (int k = 0; k < s.len(); k++) ln.push_back(s[k]);
    queue_line(ln);
  endtask

  // Mostly well-formed lines with random content; some noise, some damaged
  task automatic build_line();
    logic [7:0] ln[$];
    int         n;
    int         labels;
    int         pos;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 8);
      for (int k = 0; k < n; k++) ln.push_back(any_byte());
    end else begin
      for (int k = 0; k < 10; k++) ln.push_back(CMD_WORD[79 - 8*k -: 8]);
      n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
      for (int k = 0; k < n; k++) ln.push_back(pick_blank());
      ln.push_back(CH_LT);
      if ($urandom_range(0, 7) == 0) begin
        ln.push_back(CH_GT);
      end else begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) ln.push_back(pick_mailbox_byte());
        ln.push_back(CH_AT);
        labels = $urandom_range(1, 3);
        for (int k = 0; k < labels; k++) begin
          if (k != 0) ln.push_back(CH_DOT);
          // Now and then open a label with something other than a letter
          if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
              0:       ln.push_back(pick_numeral());
              1:       ln.push_back(CH_DOT);
              2:       ln.push_back(CH_GT);
              default: ln.push_back(8'h2D);
            endcase
          end else begin
            ln.push_back(pick_letter());
          end
          n = $urandom_range(0, 4);
          for (int j = 0; j < n; j++)
            ln.push_back(($urandom_range(0, 2) == 0) ? pick_numeral() : pick_letter());
        end
        ln.push_back(CH_GT);
      end
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) ln.push_back(any_byte());
      end
      pos = $urandom_range(0, ln.size() - 1);
      case ($urandom_range(0, 11))
        0: ln[pos] = any_byte();
        1: ln[pos] = pick_special();
        2: ln[pos] = pick_blank();
        3: ln[pos] = ln[pos] ^ 8'h20;
        4: begin
          n = $urandom_range(1, ln.size());
          while (ln.size() > n) void'(ln.pop_back());
        end
        default: ;
      endcase
    end
    queue_line(ln);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of byte transfers with random gaps between them
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_byte(byte_in, line_end);
        bytes_taken <= bytes_taken + 1;
      end
      // Hold the payload while stalled; otherwise the slot is free
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (line_q.size() != 0) begin
          next_byte = line_q.pop_front();
          in_valid  <= 1'b1;
          byte_in   <= next_byte.data;
          line_end  <= next_byte.is_tail;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each verdict transfer against the oldest prediction,
  // and drive the output stall on a pattern of its own
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("verdict transfer with nothing expected: actual %0d", verdict);
          fail_count <= fail_count + 1;
        end else begin
          want_verdict = verdict_q.pop_front();
          if (verdict !== want_verdict) begin
            $error("verdict mismatch: expected %0d, actual %0d", want_verdict, verdict);
            fail_count <= fail_count + 1;
          end
        end
      end

      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_FLOWING: out_stall <= 1'b0;
        RX_LIGHT:   out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
        default:    out_stall <= ((mode_left % 7) < 3);
      endcase
    end
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    rearm_parser();

    // Empty path, then text after '>' that must be swallowed up to the line end
    queue_text("MAIL FROM:<>x");
    // Byte extremes as one-byte lines
    queue_line('{8'h00});
    queue_line('{8'hFF});
    // Line ends inside the command word
    queue_text("MAIL");

    while (line_q.size() < RANDOM_BYTES) build_line();
    total_bytes = line_q.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken != total_bytes) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
